[src/assert_macros.svh]
// Concurrent assertion macros shared by the RTL.
// Depends on nothing; bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[src/lkv_pkg.sv]
// Types and constants for the LRU key/value cache.
// No dependencies.
package lkv_pkg;

    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;
    localparam int ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic signed [DATA_W-1:0]  key;
        logic signed [DATA_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic                      hit;
        logic signed [DATA_W-1:0]  read_value;
    } t_rsp;

endpackage

[src/lkv_lookup.sv]
// Parallel key compare and first-free slot pick for the LRU cache.
// Depends on lkv_pkg.
module lkv_lookup
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic [ENTRIES-1:0] i_valid,
    input  logic [DATA_W-1:0]  i_keys [ENTRIES],
    input  logic [DATA_W-1:0]  i_key,
    input  logic [ENTRIES-1:0] i_avail,
    output logic [ENTRIES-1:0] o_match,
    output logic               o_hit,
    output logic [ENTRIES-1:0] o_free
);

    logic [ENTRIES-1:0] empty;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_match[i] = i_valid[i] && (i_keys[i] == i_key);
        end
    end

    assign o_hit = |o_match;

    // lowest empty slot, one-hot
    assign empty  = ~i_avail;
    assign o_free = empty & ~(empty - {{(ENTRIES-1){1'b0}}, 1'b1});

endmodule

[src/lru_key_value_cache_unit.sv]
// Top level of the LRU key/value cache: entry table, recency ranks, pipeline.
// Depends on lkv_pkg, lkv_lookup and assert_macros.svh.
//
//  channel   direction  handshake              beat
//  request   in         start & !busy          t_req {action, key, value}
//  response  out        o_rsp_valid (strobe)   t_rsp {hit, read_value}
//  config    in         i_cfg_valid & o_cfg_ready  capacity
//
// One request per cycle; busy stays low. A get's response strobes after its beat
// has passed the input register, then the result register. Puts give no beat.
// Synchronous active-low reset empties the table and sets capacity to 16.
// The receiver cannot stall; every response is on the ports for one cycle.
`include "assert_macros.svh"
module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [DATA_W-1:0]  r_key  [ENTRIES];
    logic [DATA_W-1:0]  r_val  [ENTRIES];
    logic [RW-1:0]      r_rank [ENTRIES];
    logic [RW-1:0]      n_rank [ENTRIES];
    logic [OW-1:0]      r_occ, n_occ;
    logic [CAP_W-1:0]   r_cap;
    logic               r_req_valid;
    t_req               r_req;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp, n_rsp;

    logic [ENTRIES-1:0] match, free, evict, keep, key_we, val_we;
    logic               hit, is_put, full;
    logic [DATA_W-1:0]  sel_value;
    logic [RW-1:0]      sel_rank;
    logic [CW-1:0]      cap_eff;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign is_put = (r_req.action == ACT_PUT);

    lkv_lookup #(
        .ENTRIES (ENTRIES)
    ) u_lookup (
        .i_valid (r_valid),
        .i_keys  (r_key),
        .i_key   (r_req.key),
        .i_avail (keep),
        .o_match (match),
        .o_hit   (hit),
        .o_free  (free)
    );

    always_comb begin
        sel_value = '0;
        sel_rank  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                sel_value = sel_value | r_val[i];
                sel_rank  = sel_rank | r_rank[i];
            end
        end
    end

    always_comb begin
        cap_eff = CW'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = CW'(1);
        end
        if (cap_eff > CW'(ENTRIES)) begin
            cap_eff = CW'(ENTRIES);
        end
    end

    assign full = (CW'(r_occ) >= cap_eff);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            evict[i] = full && r_valid[i] && (CW'(r_rank[i]) >= (cap_eff - CW'(1)));
        end
    end

    assign keep = r_valid & ~evict;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_occ   = r_occ;
        key_we  = '0;
        val_we  = '0;
        if (r_req_valid) begin
            if (hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] < sel_rank)) begin
                        n_rank[i] = RW'(r_rank[i] + 1'b1);
                    end
                    if (match[i]) begin
                        n_rank[i] = '0;
                    end
                end
                if (is_put) begin
                    val_we = match;
                end
            end else if (is_put) begin
                n_valid = keep | free;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (keep[i]) begin
                        n_rank[i] = RW'(r_rank[i] + 1'b1);
                    end
                    if (free[i]) begin
                        n_rank[i] = '0;
                    end
                end
                key_we = free;
                val_we = free;
                // after eviction the survivors hold ranks 0..cap-2
                n_occ  = full ? OW'(cap_eff) : OW'(r_occ + 1'b1);
            end
        end
    end

    always_comb begin
        n_rsp_valid      = r_req_valid && !is_put;
        n_rsp.hit        = hit;
        n_rsp.read_value = hit ? sel_value : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_RST;
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_req_valid <= start && !busy;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_rsp  <= n_rsp;
        r_rank <= n_rank;
        for (int i = 0; i < ENTRIES; i++) begin
            if (key_we[i]) begin
                r_key[i] <= r_req.key;
            end
            if (val_we[i]) begin
                r_val[i] <= r_req.value;
            end
        end
    end

    `ASSERT_ALWAYS(a_occ_count, i_clk, i_rst_n, $countones(r_valid) == r_occ)
    `ASSERT_ALWAYS(a_one_match, i_clk, i_rst_n, $onehot0(match))
    `ASSERT_IMPLIES(a_rsp_src, i_clk, i_rst_n, r_rsp_valid, $past(r_req_valid && !is_put))
    `ASSERT_IMPLIES(a_put_fills, i_clk, i_rst_n, r_req_valid && is_put, ##1 (r_occ != '0))

endmodule

[tb/sv/tb_lru_key_value_cache_unit.sv]
`timescale 1ns / 100ps
// Testbench for lru_key_value_cache_unit: directed and random get/put traffic,
// each get response checked against an in-bench LRU table. Depends on lkv_pkg.
module tb_lru_key_value_cache_unit;
    import lkv_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int WD_LIMIT    = 2000;
    localparam int PHASE_ITEMS = 78;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_rsp_valid;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data = CAP_RST;

    // LRU table mirror
    bit                ent_vld  [ENTRIES];
    logic [DATA_W-1:0] ent_key  [ENTRIES];
    logic [DATA_W-1:0] ent_val  [ENTRIES];
    int unsigned       ent_rank [ENTRIES];
    int unsigned       occ;
    logic [CAP_W-1:0]  cap_reg;

    t_rsp pending_reads[$];
    int   mismatch_cnt = 0;
    int   idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    lru_key_value_cache_unit #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Applies one request to the table; returns 1 when a response beat is due.
    function automatic bit cache_apply(input t_req r, output t_rsp rsp);
        int          slot;
        int unsigned limit;
        int unsigned aged;
        slot = -1;
        rsp = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && ent_vld[i] && ent_key[i] == r.key) slot = i;
        if (slot >= 0) begin
            if (r.action == ACT_GET) begin
                rsp.hit = 1'b1;
                rsp.read_value = ent_val[slot];
            end else begin
                ent_val[slot] = r.value;
            end
            aged = ent_rank[slot];
            for (int i = 0; i < ENTRIES; i++)
                if (ent_vld[i] && ent_rank[i] < aged) ent_rank[i]++;
            ent_rank[slot] = 0;
            return r.action == ACT_GET;
        end
        if (r.action == ACT_GET) return 1'b1;
        limit = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
        if (occ >= limit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (ent_vld[i] && ent_rank[i] >= limit - 1) begin
                    ent_vld[i] = 1'b0;
                    occ--;
                end
            end
        end
        for (int i = 0; i < ENTRIES; i++)
            if (ent_vld[i]) ent_rank[i]++;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !ent_vld[i]) slot = i;
        ent_vld[slot] = 1'b1;
        ent_key[slot] = r.key;
        ent_val[slot] = r.value;
        ent_rank[slot] = 0;
        occ++;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        t_rsp due;
        if (i_rst_n) begin
            if (o_rsp_valid) begin
                if (pending_reads.size() == 0) begin
                    $error("hit: no beat expected, got %0d", o_rsp.hit);
                    mismatch_cnt++;
                end else begin
                    want = pending_reads.pop_front();
                    if (o_rsp.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_rsp.hit);
                        mismatch_cnt++;
                    end
                    if (o_rsp.read_value !== want.read_value) begin
                        $error("read_value: expected %08h, got %08h",
                               want.read_value, o_rsp.read_value);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) cap_reg = i_cfg_data;
            if (start && !busy) begin
                if (cache_apply(i_req, due)) pending_reads.push_back(due);
            end
            if (o_rsp_valid || (i_cfg_valid && o_cfg_ready) || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_req(input t_action act, input logic [DATA_W-1:0] k,
                            input logic [DATA_W-1:0] v);
        t_req r;
        r.action = act;
        r.key = k;
        r.value = v;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drain all get responses, then let trailing puts retire.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        wait_idle();
        i_cfg_data <= c;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_req(ACT_GET, 32'h0000_0000, 32'hffff_ffff);
        send_req(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_req(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_req(ACT_PUT, 32'h0000_0000, 32'hffff_ffff);
        send_req(ACT_PUT, 32'hffff_ffff, 32'h0000_0000);
        send_req(ACT_GET, 32'h8000_0000, 32'h0);
        send_req(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_req(ACT_GET, 32'h0000_0000, 32'h0);
        send_req(ACT_GET, 32'hffff_ffff, 32'h0);
        send_req(ACT_PUT, 32'h0000_0000, 32'h1234_5678);
        send_req(ACT_GET, 32'h0000_0000, 32'h0);
        send_req(ACT_GET, 32'h0000_0001, 32'ha5a5_a5a5);
    endtask

    task automatic test_lru_eviction();
        write_capacity(5'd2);
        send_req(ACT_PUT, 32'h0000_00a1, 32'h1111_1111);
        send_req(ACT_PUT, 32'h0000_00b2, 32'h2222_2222);
        send_req(ACT_GET, 32'h0000_00a1, 32'h0);
        send_req(ACT_PUT, 32'h0000_00c3, 32'h3333_3333);
        send_req(ACT_GET, 32'h0000_00b2, 32'h0);
        send_req(ACT_GET, 32'h0000_00a1, 32'h0);
        send_req(ACT_GET, 32'h0000_00c3, 32'h0);
    endtask

    // Lower capacity below occupancy: next new key flushes the older entries.
    task automatic test_capacity_shrink();
        write_capacity(5'd16);
        for (int i = 0; i < 6; i++) send_req(ACT_PUT, 32'h100 + i, $urandom);
        write_capacity(5'd1);
        send_req(ACT_PUT, 32'h0000_0200, 32'hdead_beef);
        send_req(ACT_GET, 32'h0000_0100, 32'h0);
        send_req(ACT_GET, 32'h0000_0200, 32'h0);
    endtask

    task automatic test_random_phase(input logic [CAP_W-1:0] cap);
        logic [DATA_W-1:0] pool [24];
        logic [DATA_W-1:0] k;
        t_action           act;
        int                pool_n;
        int                burst;
        int                gap;
        int                n;
        write_capacity(cap);
        pool_n = $urandom_range(2, 22);
        foreach (pool[i]) pool[i] = $urandom;
        if ($urandom_range(0, 1) != 0) begin
            pool[0] = 32'h8000_0000;
            pool[1] = 32'h7fff_ffff;
        end
        n = 0;
        while (n < PHASE_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < PHASE_ITEMS; b++) begin
                act = ($urandom_range(0, 1) != 0) ? ACT_PUT : ACT_GET;
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = pool[$urandom_range(0, pool_n - 1)];
                send_req(act, k, $urandom);
                n++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_random_traffic();
        test_random_phase(5'd16);
        test_random_phase(5'd0);
        test_random_phase(5'd1);
        test_random_phase(5'd31);
        test_random_phase(5'($urandom_range(2, 15)));
        test_random_phase(5'($urandom_range(17, 30)));
        test_random_phase(5'd4);
        test_random_phase(5'd16);
    endtask

    initial begin
        cap_reg = CAP_RST;
        occ = 0;
        foreach (ent_vld[i]) ent_vld[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_lru_eviction();
        test_capacity_shrink();
        test_random_traffic();
        wait_idle();
        if (mismatch_cnt == 0 && pending_reads.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
